// ----- rtl/spsv_pkg.sv -----
package spsv_pkg;

    // Width of the candidate and prime fields on the stream ports
    localparam int CAND_WIDTH = 16;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // Status of the remainder unit toward the sequencer
    typedef struct packed {
        logic done;      // one-cycle pulse: remainder is final
        logic divides;   // divisor is nonzero and leaves no remainder
    } t_rem_stat;

endpackage

// ----- rtl/spsv_cand_if.sv -----
interface spsv_cand_if;
    logic                            valid;
    logic                            ready;
    logic [spsv_pkg::CAND_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

// ----- rtl/spsv_prime_if.sv -----
interface spsv_prime_if;
    logic                            valid;
    logic                            ready;
    logic [spsv_pkg::CAND_WIDTH-1:0] prime;
    logic                            unconfirmed;

    modport source (output valid, output prime, output unconfirmed, input ready);
    modport sink   (input valid, input prime, input unconfirmed, output ready);
endinterface

// ----- rtl/spsv_cell_mem.sv -----
module spsv_cell_mem #(
    parameter int NUM_CELLS   = 64,
    parameter int VALUE_WIDTH = 16,
    parameter int ADDR_WIDTH  = 6
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [ADDR_WIDTH-1:0]  i_wr_addr,
    input  logic [VALUE_WIDTH-1:0] i_wr_data,
    input  logic                   i_rd_en,
    input  logic [ADDR_WIDTH-1:0]  i_rd_addr,
    output logic [VALUE_WIDTH-1:0] o_rd_data
);

    logic [VALUE_WIDTH-1:0] r_cells [NUM_CELLS];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_cells[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_cells[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/spsv_rem_unit.sv -----
module spsv_rem_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output spsv_pkg::t_rem_stat    o_stat
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_dvd, n_dvd;
    logic [VALUE_WIDTH-1:0] r_dvs, n_dvs;
    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH:0]   w_dvs_ext;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign w_trial   = {r_rem, r_dvd[VALUE_WIDTH-1]};
    assign w_dvs_ext = {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(VALUE_WIDTH - 1);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= w_dvs_ext) begin
                n_rem = VALUE_WIDTH'(w_trial - w_dvs_ext);
            end else begin
                n_rem = w_trial[VALUE_WIDTH-1:0];
            end
            n_dvd = {r_dvd[VALUE_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_stat.done    = r_done;
    assign o_stat.divides = (r_rem == '0) && (r_dvs != '0);

endmodule

// ----- rtl/streaming_prime_sieve_core.sv -----
// Streaming prime sieve. Send candidates in increasing order (2, 3, 4, ...);
// each candidate is tested against every prime stored so far, one stored prime
// at a time. A candidate that none of them divides comes out on the result
// channel: while the cell memory has room it is stored and flagged confirmed
// (unconfirmed = 0); once all NUM_CELLS cells hold primes it is emitted with
// unconfirmed = 1 and not stored. Candidates 0 and 1, and candidates that a
// stored prime divides, produce no result. Only the low VALUE_WIDTH bits of a
// candidate are used. The block takes one candidate at a time: for each stored
// prime that it meets before the candidate is decided, it reads the cell, runs
// the bit-serial remainder unit (VALUE_WIDTH steps per divisor) and then
// decides whether to stop, read the next prime or emit the survivor. A
// finished result sits in an output register, so the next candidate is taken
// while the result waits for its consumer. No clearing pass is needed after
// reset: only cells below the fill count are ever read.
module streaming_prime_sieve_core #(
    parameter int NUM_CELLS   = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    spsv_cand_if.sink           i_cand,
    spsv_prime_if.source        o_prime
);

    localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W = $clog2(NUM_CELLS + 1);

    spsv_pkg::t_state    r_state, n_state;
    spsv_pkg::t_rem_stat w_rem_stat;

    logic [CNT_W-1:0]       r_filled, n_filled;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       w_idx_nx;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [31:0]            w_cand_ext;
    logic [31:0]            w_value_ext;

    logic                   r_out_valid, n_out_valid;
    logic [spsv_pkg::CAND_WIDTH-1:0] r_out_prime, n_out_prime;
    logic                   r_out_unconf, n_out_unconf;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_out_free;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;
    logic                   w_wr_en;
    logic                   w_rem_start;
    logic [VALUE_WIDTH-1:0] w_rd_data;

    // Fit the 16-bit request to the internal value width and back
    assign w_cand_ext  = 32'(i_cand.candidate);
    assign w_value     = w_cand_ext[VALUE_WIDTH-1:0];
    assign w_value_ext = 32'(r_value);

    assign i_cand.ready = (r_state == spsv_pkg::S_IDLE);
    assign w_accept     = i_cand.valid && i_cand.ready;
    assign w_full       = (r_filled == CNT_W'(NUM_CELLS));
    assign w_out_free   = !r_out_valid || o_prime.ready;
    assign w_idx_nx     = r_idx + CNT_W'(1);

    spsv_cell_mem #(
        .NUM_CELLS   (NUM_CELLS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .ADDR_WIDTH  (IDX_W)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_filled[IDX_W-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    spsv_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_value),
        .i_divisor  (w_rd_data),
        .o_stat     (w_rem_stat)
    );

    // Sequencer: read a stored prime, run the remainder, decide, advance.
    // The only write happens in S_EMIT, after all reads of this request, and
    // lands above every cell a later request reads first, so reads and writes
    // of one cell never overlap.
    always_comb begin
        n_state      = r_state;
        n_filled     = r_filled;
        n_idx        = r_idx;
        n_value      = r_value;
        n_out_valid  = r_out_valid && !o_prime.ready;
        n_out_prime  = r_out_prime;
        n_out_unconf = r_out_unconf;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx[IDX_W-1:0];
        w_wr_en      = 1'b0;
        w_rem_start  = 1'b0;

        unique case (r_state)
            spsv_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_value = w_value;
                    if (w_value < VALUE_WIDTH'(2)) begin
                        // drop 0 and 1
                        n_state = spsv_pkg::S_IDLE;
                    end else if (r_filled == '0) begin
                        n_state = spsv_pkg::S_EMIT;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_idx     = '0;
                        n_state   = spsv_pkg::S_READ;
                    end
                end
            end
            spsv_pkg::S_READ: begin
                // read data is valid now; hand it to the remainder unit
                w_rem_start = 1'b1;
                n_state     = spsv_pkg::S_DIV;
            end
            spsv_pkg::S_DIV: begin
                if (w_rem_stat.done) begin
                    if (w_rem_stat.divides) begin
                        n_state = spsv_pkg::S_IDLE;
                    end else if (w_idx_nx == r_filled) begin
                        n_state = spsv_pkg::S_EMIT;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_idx_nx[IDX_W-1:0];
                        n_idx     = w_idx_nx;
                        n_state   = spsv_pkg::S_READ;
                    end
                end
            end
            spsv_pkg::S_EMIT: begin
                // hold until the output register can take the survivor
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_prime  = w_value_ext[spsv_pkg::CAND_WIDTH-1:0];
                    n_out_unconf = w_full;
                    if (!w_full) begin
                        w_wr_en  = 1'b1;
                        n_filled = r_filled + CNT_W'(1);
                    end
                    n_state = spsv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spsv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spsv_pkg::S_IDLE;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_value      <= n_value;
        r_out_prime  <= n_out_prime;
        r_out_unconf <= n_out_unconf;
    end

    assign o_prime.valid       = r_out_valid;
    assign o_prime.prime       = r_out_prime;
    assign o_prime.unconfirmed = r_out_unconf;

    // A cell is written only while the table still has room
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_filled < CNT_W'(NUM_CELLS)))
        else $error("cell write with a full table");

    // A new result appears only right after the emit step
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_prime.valid) |-> $past(r_state == spsv_pkg::S_EMIT))
        else $error("result appeared outside the emit step");

    // The remainder finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_stat.done |-> (r_state == spsv_pkg::S_DIV))
        else $error("remainder finished outside the divide step");

    // A request below two leaves the block idle and the table untouched
    a_drop_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_value < VALUE_WIDTH'(2)))
        |=> ((r_state == spsv_pkg::S_IDLE) && $stable(r_filled)))
        else $error("candidate below two was not dropped");

endmodule

// ----- bench/tb_streaming_prime_sieve_core.sv -----
`timescale 1ns / 1ps

module tb_streaming_prime_sieve_core;

    localparam int NUM_CELLS   = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int ITEM_TARGET = 1250;
    localparam int TAIL_ITEMS  = 100;
    localparam int PRINT_LIMIT = 50;
    // One candidate walking a full table, twice over, plus slack
    localparam int DRAIN_CYCLES = 2 * (2 + NUM_CELLS * (VALUE_WIDTH + 2)) + 64;

    typedef logic [spsv_pkg::CAND_WIDTH-1:0] t_value;

    localparam t_value VALUE_MASK = t_value'((64'd1 << VALUE_WIDTH) - 1);

    typedef struct packed {
        t_value prime;
        logic   unconfirmed;
    } t_sieve_result;

    typedef enum int {
        NOISE_ANY,
        NOISE_LOW,
        NOISE_REPEAT,
        NOISE_TOP
    } t_noise_kind;

    logic i_clk;
    logic i_rst_n;

    spsv_cand_if  cand_bus ();
    spsv_prime_if prime_bus ();

    streaming_prime_sieve_core #(
        .NUM_CELLS   (NUM_CELLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand_bus),
        .o_prime (prime_bus)
    );

    // Predicted table contents and the survivors still owed by the block
    t_value        prime_table [NUM_CELLS];
    int unsigned   primes_held;
    t_sieve_result survivor_q [$];

    int unsigned items_sent;
    int unsigned error_count;
    int unsigned ready_hold;
    bit          idle_enabled;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Update the predicted table and queue any survivor of this candidate
    function automatic void sieve_candidate(input t_value raw);
        t_value value;
        bit     divided;
        value   = raw & VALUE_MASK;
        divided = 1'b0;
        if (value < 2) begin
            return;
        end
        for (int unsigned i = 0; i < primes_held; i++) begin
            if (value % prime_table[i] == 0) begin
                divided = 1'b1;
            end
        end
        if (divided) begin
            return;
        end
        if (primes_held < NUM_CELLS) begin
            prime_table[primes_held] = value;
            primes_held++;
            survivor_q.push_back('{prime: value, unconfirmed: 1'b0});
        end else begin
            survivor_q.push_back('{prime: value, unconfirmed: 1'b1});
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    // Compare every accepted result with the oldest predicted survivor
    always @(posedge i_clk) begin
        t_sieve_result want;
        if (i_rst_n && prime_bus.valid && prime_bus.ready) begin
            if (survivor_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result prime=%0d unconfirmed=%0b",
                                          prime_bus.prime, prime_bus.unconfirmed));
            end else begin
                want = survivor_q.pop_front();
                if (prime_bus.prime !== want.prime) begin
                    report_mismatch($sformatf("prime got %0d want %0d",
                                              prime_bus.prime, want.prime));
                end
                if (prime_bus.unconfirmed !== want.unconfirmed) begin
                    report_mismatch($sformatf("unconfirmed got %b want %b for prime %0d",
                                              prime_bus.unconfirmed, want.unconfirmed,
                                              want.prime));
                end
            end
        end
    end

    // Result side: stall in bursts while idling is on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            prime_bus.ready <= 1'b0;
        end else if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
            prime_bus.ready <= 1'b0;
        end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(1, 16) - 1;
            prime_bus.ready <= 1'b0;
        end else begin
            prime_bus.ready <= 1'b1;
        end
    end

    // Present one candidate, optionally after a gap, and hold until taken
    task automatic send_candidate(input t_value value);
        @(negedge i_clk);
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            cand_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        cand_bus.valid     <= 1'b1;
        cand_bus.candidate <= value;
        @(posedge i_clk);
        while (!cand_bus.ready) begin
            @(posedge i_clk);
        end
        sieve_candidate(value);
        items_sent++;
    endtask

    // Increasing stream of candidates, as a generator would send them
    task automatic send_run(input t_value start, input int unsigned length,
                            input int unsigned stride);
        int unsigned next_value;
        next_value = 32'(start);
        for (int unsigned k = 0; k < length; k++) begin
            send_candidate(t_value'(next_value));
            next_value = next_value + stride;
            if (next_value > VALUE_MASK) begin
                break;
            end
        end
    endtask

    task automatic send_noise();
        t_noise_kind kind;
        kind = t_noise_kind'($urandom_range(0, 3));
        case (kind)
            NOISE_ANY: begin
                send_candidate(t_value'($urandom));
            end
            NOISE_LOW: begin
                send_candidate(t_value'($urandom_range(0, 3)));
            end
            NOISE_REPEAT: begin
                // Repeat a stored prime: it must be dropped
                send_candidate(prime_table[$urandom_range(0, primes_held - 1)]);
            end
            default: begin
                send_candidate(VALUE_MASK - t_value'($urandom_range(0, 7)));
            end
        endcase
    endtask

    task automatic pick_run_start(output t_value start);
        if ($urandom_range(0, 7) == 0) begin
            start = t_value'($urandom_range(0, 400));
        end else begin
            start = t_value'($urandom_range(2, VALUE_MASK));
        end
    endtask

    // Values below two, repeats, decreasing steps and the top of the range
    task automatic run_edge_cases();
        t_value corner_values [20] = '{
            0, 1, 2, 2, 3, 4, 1, 5, 3, 7,
            9, 65535, 65534, 65533, 32768, 11, 13, 6, 0, 15
        };
        idle_enabled = 1'b1;
        foreach (corner_values[i]) begin
            send_candidate(corner_values[i]);
        end
    endtask

    // Count upward until every cell holds a prime, then past it
    task automatic run_table_fill();
        t_value next_value;
        next_value   = t_value'(16);
        idle_enabled = 1'b1;
        while (primes_held < NUM_CELLS) begin
            send_candidate(next_value);
            next_value++;
        end
        send_run(next_value, 24, 1);
    endtask

    task automatic run_random_streams();
        t_value start;
        while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
            idle_enabled = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0) begin
                pick_run_start(start);
                send_run(start, $urandom_range(8, 40), ($urandom_range(0, 3) == 0) ? 2 : 1);
            end else begin
                repeat ($urandom_range(1, 6)) send_noise();
            end
        end
    endtask

    // Full-rate finish with no idling on either side
    task automatic run_steady_tail();
        t_value start;
        idle_enabled = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0) begin
                pick_run_start(start);
                send_run(start, $urandom_range(8, 40), 1);
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cand_bus.valid     = 1'b0;
        cand_bus.candidate = '0;
        primes_held        = 0;
        items_sent         = 0;
        error_count        = 0;
        ready_hold         = 0;
        idle_enabled       = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_edge_cases();
        run_table_fill();
        run_random_streams();
        run_steady_tail();

        @(negedge i_clk);
        cand_bus.valid <= 1'b0;

        while (survivor_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #15000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
